[rtl/motor_feedback_tracker_macros.svh]
// Assertion macros for the motor feedback tracker.
// Used by mft_core, the RTL module that checks its own state; no other dependencies.
`ifndef MOTOR_FEEDBACK_TRACKER_MACROS_SVH
`define MOTOR_FEEDBACK_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted.
`define MFT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("motor_feedback_tracker: assertion failed");

// Clocked check that also holds through reset.
`define MFT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("motor_feedback_tracker: assertion failed");

`else

`define MFT_ASSERT(label, prop)
`define MFT_ASSERT_ALWAYS(label, prop)

`endif

`endif

[rtl/mft_pkg.sv]
// Shared types and constants for the motor feedback tracker.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package mft_pkg;

  localparam int ROUND_BITS_DEF = 32;

  localparam int ANGLE_W = 13;
  localparam int VALUE_W = 16;
  localparam int LIMIT_W = 15;
  localparam int TIMEOUT_W = 16;
  localparam int SILENCE_W = 17;
  localparam int REV_W = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 96;

  localparam logic [ANGLE_W-1:0] WRAP_LOW = 13'd2048;
  localparam logic [ANGLE_W-1:0] WRAP_HIGH = 13'd6144;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX = 17'h1FFFF;
  localparam logic [LIMIT_W-1:0] VOLT_LIMIT_RST = 15'd30000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd5000;

  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;

  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_COMMAND = 2'd1,
    OP_TICK    = 2'd2,
    OP_ROUNDS  = 2'd3
  } opcode_t;

  // Link state machine, one-hot.
  typedef enum logic [2:0] {
    LINK_DISC = 3'b001,
    LINK_IDLE = 3'b010,
    LINK_RUN  = 3'b100
  } link_t;

  // Codes of the link_state result field.
  localparam logic [1:0] CODE_DISC = 2'd0;
  localparam logic [1:0] CODE_IDLE = 2'd1;
  localparam logic [1:0] CODE_RUN  = 2'd2;

  typedef struct packed {
    opcode_t                    opcode;
    logic [ANGLE_W-1:0]         frame_angle;
    logic signed [VALUE_W-1:0]  frame_speed;
    logic signed [VALUE_W-1:0]  frame_current;
    logic signed [VALUE_W-1:0]  command_voltage;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  drive_voltage;
    logic [1:0]                 link_state;
    logic                       connected;
    logic [ANGLE_W-1:0]         angle_now;
    logic signed [VALUE_W-1:0]  speed_now;
    logic signed [VALUE_W-1:0]  current_now;
    logic signed [REV_W-1:0]    revolutions;
  } result_t;

  // Handshake between the pipeline stages.
  typedef struct packed {
    logic advance;
  } pipe_ctl_t;

  function automatic logic [1:0] link_code(link_t m);
    logic [1:0] c;
    unique case (m)
      LINK_IDLE: c = CODE_IDLE;
      LINK_RUN:  c = CODE_RUN;
      default:   c = CODE_DISC;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/mft_in_stage.sv]
// Input register of the motor feedback tracker: holds one accepted item.
// Depends on mft_pkg.
`default_nettype none

module mft_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire mft_pkg::item_t in_item,
  input  wire logic          load_ok,
  output mft_pkg::pipe_ctl_t ctl,
  output mft_pkg::item_t     item
);
  import mft_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Item leaves when the result register can take its result.
  assign ctl.advance    = valid_r & load_ok;
  assign in_tready      = ~valid_r | load_ok;
  assign item           = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (ctl.advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/mft_core.sv]
// Link state, stored readings, revolution counter and config registers.
// Depends on mft_pkg and motor_feedback_tracker_macros.svh.
`default_nettype none

`include "motor_feedback_tracker_macros.svh"

module mft_core #(
  parameter int ROUND_BITS = mft_pkg::ROUND_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [mft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mft_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire mft_pkg::pipe_ctl_t                ctl,
  input  wire mft_pkg::item_t                    item,
  output mft_pkg::result_t                       result
);
  import mft_pkg::*;

  logic [LIMIT_W-1:0]         max_v_r;
  logic [TIMEOUT_W-1:0]       timeout_r;
  link_t                      link_r, link_nxt;
  logic signed [VALUE_W-1:0]  volt_r, volt_nxt;
  logic [ANGLE_W-1:0]         angle_r, angle_nxt;
  logic signed [VALUE_W-1:0]  speed_r, speed_nxt;
  logic signed [VALUE_W-1:0]  cur_r, cur_nxt;
  logic [ROUND_BITS-1:0]      turn_r, turn_nxt;
  logic                       seen_r, seen_nxt;
  logic [SILENCE_W-1:0]       sil_r, sil_nxt;
  logic                       tick_over;

  logic signed [VALUE_W:0]    lim_s;
  logic signed [VALUE_W:0]    cmd_s;
  logic signed [VALUE_W:0]    clamp_s;
  logic [REV_W-1:0]           rev;

  always_comb begin
    lim_s = signed'({2'b00, max_v_r});
    cmd_s = {item.command_voltage[VALUE_W-1], item.command_voltage};
    if (cmd_s > lim_s) begin
      clamp_s = lim_s;
    end else if (cmd_s < -lim_s) begin
      clamp_s = -lim_s;
    end else begin
      clamp_s = cmd_s;
    end
  end

  always_comb begin
    link_nxt  = link_r;
    volt_nxt  = volt_r;
    angle_nxt = angle_r;
    speed_nxt = speed_r;
    cur_nxt   = cur_r;
    turn_nxt  = turn_r;
    seen_nxt  = seen_r;
    sil_nxt   = sil_r;
    tick_over = 1'b0;
    unique case (item.opcode)
      OP_FRAME: begin
        angle_nxt = item.frame_angle;
        speed_nxt = item.frame_speed;
        cur_nxt   = item.frame_current;
        sil_nxt   = '0;
        seen_nxt  = 1'b1;
        if (link_r == LINK_DISC) begin
          link_nxt = LINK_IDLE;
        end
        // Wrap across zero: high to low counts up, low to high counts down.
        if (seen_r) begin
          if (item.frame_angle < WRAP_LOW && angle_r > WRAP_HIGH) begin
            turn_nxt = turn_r + 1'b1;
          end else if (item.frame_angle > WRAP_HIGH && angle_r < WRAP_LOW) begin
            turn_nxt = turn_r - 1'b1;
          end
        end
      end
      OP_COMMAND: begin
        volt_nxt = clamp_s[VALUE_W-1:0];
        if (link_r == LINK_IDLE) begin
          link_nxt = LINK_RUN;
        end
      end
      OP_TICK: begin
        if (sil_r != SILENCE_MAX) begin
          sil_nxt = sil_r + 1'b1;
        end
        tick_over = (sil_nxt > {1'b0, timeout_r});
        if (tick_over) begin
          link_nxt = LINK_DISC;
        end
        // Drop a stale command so it is not driven when the link returns.
        if (link_nxt == LINK_DISC) begin
          volt_nxt = '0;
        end
      end
      OP_ROUNDS: begin
        turn_nxt = '0;
      end
      default: begin
        turn_nxt = turn_r;
      end
    endcase
  end

  generate
    if (ROUND_BITS >= REV_W) begin : g_rev_cut
      assign rev = turn_nxt[REV_W-1:0];
    end else begin : g_rev_ext
      assign rev = {{(REV_W-ROUND_BITS){turn_nxt[ROUND_BITS-1]}}, turn_nxt};
    end
  endgenerate

  always_comb begin
    result.drive_voltage = (link_nxt == LINK_DISC) ? '0 : volt_nxt;
    result.link_state    = link_code(link_nxt);
    result.connected     = (link_nxt != LINK_DISC);
    result.angle_now     = angle_nxt;
    result.speed_now     = speed_nxt;
    result.current_now   = cur_nxt;
    result.revolutions   = signed'(rev);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_v_r   <= VOLT_LIMIT_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_VOLT_LIMIT) begin
        max_v_r <= cfg_data[LIMIT_W-1:0];
      end else if (cfg_index == REG_TIMEOUT_TICKS) begin
        timeout_r <= cfg_data[TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= LINK_DISC;
      volt_r  <= '0;
      angle_r <= '0;
      speed_r <= '0;
      cur_r   <= '0;
      turn_r  <= '0;
      seen_r  <= 1'b0;
      sil_r   <= '0;
    end else if (ctl.advance) begin
      link_r  <= link_nxt;
      volt_r  <= volt_nxt;
      angle_r <= angle_nxt;
      speed_r <= speed_nxt;
      cur_r   <= cur_nxt;
      turn_r  <= turn_nxt;
      seen_r  <= seen_nxt;
      sil_r   <= sil_nxt;
    end
  end

  `MFT_ASSERT(a_frame_connects, ctl.advance && item.opcode == OP_FRAME |=> link_r != LINK_DISC)
  `MFT_ASSERT(a_rounds_clear, ctl.advance && item.opcode == OP_ROUNDS |=> turn_r == '0)
  `MFT_ASSERT(a_timeout_drops, ctl.advance && tick_over |=> link_r == LINK_DISC && volt_r == '0)
  `MFT_ASSERT(a_no_drive_disc, link_nxt == LINK_DISC |-> result.drive_voltage == '0)
  `MFT_ASSERT_ALWAYS(a_link_onehot, !rst_n || $onehot(link_r))

endmodule

`default_nettype wire

[rtl/mft_out_stage.sv]
// Result register of the motor feedback tracker, parting the result side from the core.
// Depends on mft_pkg.
`default_nettype none

module mft_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mft_pkg::pipe_ctl_t  ctl,
  input  wire mft_pkg::result_t    result,
  output logic                     load_ok,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output mft_pkg::result_t         out_result
);
  import mft_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign load_ok    = ~valid_r | out_tready;
  assign out_tvalid = valid_r;
  assign out_result = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.advance) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      res_r <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/motor_feedback_tracker.sv]
// Top level of the motor feedback tracker: input register, core, result register.
// Depends on mft_pkg, mft_in_stage, mft_core and mft_out_stage.
//
//   channel | direction | payload
//   --------+-----------+------------------------------------------------
//   in_     | slave     | tuser opcode, tdata angle/speed/current/command
//   out_    | master    | tdata drive/state/readings/revolutions
//   cfg_    | slave     | index 0 voltage limit, index 1 timeout_ticks
//
// One item per cycle sustained while out_tready is high; an item taken into the input
// register moves into the result register once that register can take it, which
// raises out_tvalid, the core state updating on that same move.
// Reset is synchronous, active low; config is always ready.
// A stalled result holds the result register, which holds the input register.
`default_nettype none

module motor_feedback_tracker #(
  parameter int ROUND_BITS = mft_pkg::ROUND_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [12:0] frame_angle, [28:13] frame_speed, [44:29] frame_current,
  // [60:45] command_voltage, [63:61] zero
  input  wire logic [mft_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] drive_voltage, [17:16] link_state, [18] connected,
  // [31:19] angle_now, [47:32] speed_now, [63:48] current_now,
  // [95:64] revolutions
  output logic [mft_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mft_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mft_pkg::*;

  item_t     in_item;
  item_t     item;
  pipe_ctl_t ctl;
  result_t   result;
  result_t   out_result;
  logic      load_ok;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_item.opcode          = opcode_t'(in_tuser);
    in_item.frame_angle     = in_tdata[12:0];
    in_item.frame_speed     = in_tdata[28:13];
    in_item.frame_current   = in_tdata[44:29];
    in_item.command_voltage = in_tdata[60:45];
  end

  assign out_tdata = {out_result.revolutions, out_result.current_now,
                      out_result.speed_now, out_result.angle_now,
                      out_result.connected, out_result.link_state,
                      out_result.drive_voltage};

  mft_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .load_ok   (load_ok),
    .ctl       (ctl),
    .item      (item)
  );

  mft_core #(
    .ROUND_BITS (ROUND_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .item      (item),
    .result    (result)
  );

  mft_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
